/* hw/rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions of the sorted priority queue
// Sizes of the queue and its fields, and the command that the control
// hands to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Queue size and field widths.
	localparam int QUEUE_DEPTH  = 64;
	localparam int KEY_BITS     = 32;
	localparam int VALUE_BITS   = 64;
	localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRIES_BITS = 7;

	// Operation codes of the action field.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Command broadcast to the cells.
	typedef struct packed {
		logic cmp;        // compare the held key against the new key
		logic shift_out;  // remove: every cell takes its right neighbor (the tail keeps its own)
		logic shift_in;   // insert: open a slot at the insertion point
		logic replace;    // insert of a held key: overwrite its value
	} cell_cmd_t;

endpackage

/* hw/rtl/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: bounded priority queue on a chain of cells
// Key/value entries are held sorted by descending key in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
// An operation is transferred at a rising edge where start is high and busy
// is low; action selects insert or remove of the highest-key entry.
// At the transfer, every cell compares its key against the new key in
// parallel and the operation becomes pending. While it is pending, the
// combined match flag picks replace, shift-in or shift-out, and all cells
// move at once. busy is high while an operation is pending, so the next
// operation is not taken until the cells have moved.
// The result is shown for exactly one cycle with done high, from the edge at
// which the cells move; the receiver cannot stall it, and the next operation
// may be transferred at the edge that ends it.
// success is low for a remove on an empty queue and for an insert of a new
// key into a full queue; then result_key and result_value are zero.
// Reset empties the queue (the entry count is cleared; the cell contents
// are not) and drops any operation in flight.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [spq_pkg::KEY_BITS-1:0]     entry_key,
	input  logic [spq_pkg::VALUE_BITS-1:0]   entry_value,
	output logic                             done,
	output logic                             success,
	output logic [spq_pkg::KEY_BITS-1:0]     result_key,
	output logic [spq_pkg::VALUE_BITS-1:0]   result_value,
	output logic [spq_pkg::ENTRIES_BITS-1:0] entries_held
);

	localparam int DEPTH = spq_pkg::QUEUE_DEPTH;

	logic                           pending_q;
	logic                           act_q;
	logic [spq_pkg::KEY_BITS-1:0]   key_q;
	logic [spq_pkg::VALUE_BITS-1:0] value_q;
	logic [spq_pkg::CNT_BITS-1:0]   occ_q;

	logic                           done_q;
	logic                           success_q;
	logic [spq_pkg::KEY_BITS-1:0]   res_key_q;
	logic [spq_pkg::VALUE_BITS-1:0] res_value_q;

	logic                           accept;
	logic                           hit;
	logic                           full;
	logic                           empty;
	spq_pkg::cell_cmd_t             cmd;
	logic [DEPTH-1:0]               valid;

	logic [spq_pkg::KEY_BITS-1:0]   cell_key   [DEPTH];
	logic [spq_pkg::VALUE_BITS-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0]               cell_gt;
	logic [DEPTH-1:0]               cell_eq;

	assign accept = start && !pending_q;
	assign busy   = pending_q;
	assign hit    = |cell_eq;
	assign full   = (occ_q == spq_pkg::CNT_BITS'(DEPTH));
	assign empty  = (occ_q == '0);

	// Slots below the entry count hold entries.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid[i] = (spq_pkg::CNT_BITS'(i) < occ_q);
		end
	end

	// Command to the chain: compare on transfer, then move in the next cycle.
	always_comb begin
		cmd.cmp       = accept;
		cmd.shift_out = pending_q && (act_q == spq_pkg::ACT_REMOVE) && !empty;
		cmd.shift_in  = pending_q && (act_q == spq_pkg::ACT_INSERT) && !hit && !full;
		cmd.replace   = pending_q && (act_q == spq_pkg::ACT_INSERT) && hit;
	end

	// Operation capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			key_q   <= entry_key;
			value_q <= entry_value;
		end
	end

	// Control, entry count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			occ_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			pending_q <= accept;
			done_q    <= pending_q;
			if (cmd.shift_out) begin
				occ_q <= occ_q - 1'b1;
			end else if (cmd.shift_in) begin
				occ_q <= occ_q + 1'b1;
			end
		end
	end

	// Result payload, registered while the operation is pending.
	always_ff @(posedge clk) begin
		if (pending_q) begin
			if (cmd.shift_out) begin
				success_q   <= 1'b1;
				res_key_q   <= cell_key[0];
				res_value_q <= cell_value[0];
			end else if (cmd.shift_in || cmd.replace) begin
				success_q   <= 1'b1;
				res_key_q   <= key_q;
				res_value_q <= value_q;
			end else begin
				success_q   <= 1'b0;
				res_key_q   <= '0;
				res_value_q <= '0;
			end
		end
	end

	assign done         = done_q;
	assign success      = success_q;
	assign result_key   = res_key_q;
	assign result_value = res_value_q;
	assign entries_held = spq_pkg::ENTRIES_BITS'(occ_q);

	// The chain of cells, each wired to its left and right neighbors.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                           l_gt;
		logic [spq_pkg::KEY_BITS-1:0]   l_key;
		logic [spq_pkg::VALUE_BITS-1:0] l_value;
		logic [spq_pkg::KEY_BITS-1:0]   r_key;
		logic [spq_pkg::VALUE_BITS-1:0] r_value;

		if (i == 0) begin : g_head
			assign l_gt    = 1'b1;
			assign l_key   = key_q;
			assign l_value = value_q;
		end else begin : g_body
			assign l_gt    = cell_gt[i-1];
			assign l_key   = cell_key[i-1];
			assign l_value = cell_value[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_key   = cell_key[i];
			assign r_value = cell_value[i];
		end else begin : g_inner
			assign r_key   = cell_key[i+1];
			assign r_value = cell_value[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.valid       (valid[i]),
			.new_key     (accept ? entry_key : key_q),
			.new_value   (value_q),
			.left_gt     (l_gt),
			.left_key    (l_key),
			.left_value  (l_value),
			.right_key   (r_key),
			.right_value (r_value),
			.key         (cell_key[i]),
			.value       (cell_value[i]),
			.gt          (cell_gt[i]),
			.eq          (cell_eq[i])
		);
	end

	// A result strobe follows every pending operation and appears at no other time.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |=> done_q)
		else $error("result strobe missing after an operation");
	a_done_only: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(pending_q))
		else $error("result strobe without an operation");
	// The entry count never passes the depth.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= spq_pkg::CNT_BITS'(DEPTH))
		else $error("entry count beyond queue depth");
	// A failed insert is only possible on a full queue.
	a_insert_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !success_q && (act_q == spq_pkg::ACT_INSERT)) |-> full)
		else $error("insert failed on a queue that is not full");
	// At most one held key matches the new key.
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> $onehot0(cell_eq))
		else $error("more than one cell matches the key");

endmodule

/* hw/rtl/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one key/value entry, compares it against the new key, and moves
// data to or from its neighbors under the broadcast command.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spq_pkg::cell_cmd_t             cmd,
	input  logic                           valid,
	input  logic [spq_pkg::KEY_BITS-1:0]   new_key,
	input  logic [spq_pkg::VALUE_BITS-1:0] new_value,
	input  logic                           left_gt,
	input  logic [spq_pkg::KEY_BITS-1:0]   left_key,
	input  logic [spq_pkg::VALUE_BITS-1:0] left_value,
	input  logic [spq_pkg::KEY_BITS-1:0]   right_key,
	input  logic [spq_pkg::VALUE_BITS-1:0] right_value,
	output logic [spq_pkg::KEY_BITS-1:0]   key,
	output logic [spq_pkg::VALUE_BITS-1:0] value,
	output logic                           gt,
	output logic                           eq
);

	logic [spq_pkg::KEY_BITS-1:0]   key_q;
	logic [spq_pkg::VALUE_BITS-1:0] value_q;
	logic                           gt_q;
	logic                           eq_q;

	// Compare flags: this entry is held and ranks above, or equals, the new key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmd.cmp) begin
			gt_q <= valid && (key_q > new_key);
			eq_q <= valid && (key_q == new_key);
		end
	end

	// Entry storage. Remove: each cell takes its right neighbor's entry. Replace:
	// the matching cell takes the new value. Insert: cells ranking above the new
	// key stay, the first other cell takes the new entry and the rest shift right.
	always_ff @(posedge clk) begin
		if (cmd.shift_out) begin
			key_q   <= right_key;
			value_q <= right_value;
		end else if (cmd.shift_in && !gt_q) begin
			if (left_gt) begin
				key_q   <= new_key;
				value_q <= new_value;
			end else begin
				key_q   <= left_key;
				value_q <= left_value;
			end
		end else if (cmd.replace && eq_q) begin
			value_q <= new_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign gt    = gt_q;
	assign eq    = eq_q;

endmodule

/* dv/tb_sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_top: self-checking bench of the sorted priority queue
// A short table of inserts and removes covers the key and value extremes,
// value replacement and removal from an empty queue. Random workloads follow
// that fill the queue, drain it and mix both, with key collisions. Every
// transfer is run through a behavioral model of the queue, and each result
// is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_top;

	localparam int DIRECTED_ROWS = 17;
	localparam int RANDOM_ITEMS  = 1033;
	localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
	localparam int STALL_LIMIT   = 1000;
	localparam int MAX_PRINTED   = 40;

	// One result of the queue.
	typedef struct packed {
		logic                             ok;
		logic [spq_pkg::KEY_BITS-1:0]     key;
		logic [spq_pkg::VALUE_BITS-1:0]   value;
		logic [spq_pkg::ENTRIES_BITS-1:0] held;
	} queue_outcome_t;

	// One row of the directed table; fixed rows carry a typed-in result.
	typedef struct packed {
		logic                             act;
		logic [spq_pkg::KEY_BITS-1:0]     key;
		logic [spq_pkg::VALUE_BITS-1:0]   value;
		logic                             fixed;
		logic                             ok;
		logic [spq_pkg::KEY_BITS-1:0]     rkey;
		logic [spq_pkg::VALUE_BITS-1:0]   rvalue;
		logic [spq_pkg::ENTRIES_BITS-1:0] held;
	} directed_row_t;

	typedef enum int {LOAD_FILL, LOAD_DRAIN, LOAD_MIXED} workload_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic                             busy;
	logic                             action = spq_pkg::ACT_INSERT;
	logic [spq_pkg::KEY_BITS-1:0]     entry_key = '0;
	logic [spq_pkg::VALUE_BITS-1:0]   entry_value = '0;
	logic                             done;
	logic                             success;
	logic [spq_pkg::KEY_BITS-1:0]     result_key;
	logic [spq_pkg::VALUE_BITS-1:0]   result_value;
	logic [spq_pkg::ENTRIES_BITS-1:0] entries_held;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// Remove on an empty queue after reset.
		'{spq_pkg::ACT_REMOVE, 32'h0, 64'h0, 1'b1, 1'b0, 32'h0, 64'h0, 7'd0},
		// Key and value extremes.
		'{spq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1},
		'{spq_pkg::ACT_INSERT, 32'h0, 64'h0, 1'b1, 1'b1, 32'h0, 64'h0, 7'd2},
		// Same key again: the value is replaced, the count stays.
		'{spq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b1,
			1'b1, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 7'd2},
		'{spq_pkg::ACT_INSERT, 32'h8000_0000, 64'h5555_5555_5555_5555, 1'b1,
			1'b1, 32'h8000_0000, 64'h5555_5555_5555_5555, 7'd3},
		'{spq_pkg::ACT_INSERT, 32'h7FFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
			1'b1, 32'h7FFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 7'd4},
		'{spq_pkg::ACT_INSERT, 32'h0000_0001, 64'h8000_0000_0000_0001, 1'b1,
			1'b1, 32'h0000_0001, 64'h8000_0000_0000_0001, 7'd5},
		// Replace the value of the smallest key at the tail.
		'{spq_pkg::ACT_INSERT, 32'h0, 64'hFEDC_BA98_7654_3210, 1'b1,
			1'b1, 32'h0, 64'hFEDC_BA98_7654_3210, 7'd5},
		// Removes carry junk in the key and value fields; an insert replaces a held value.
		'{spq_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
			1'b0, 32'h0, 64'h0, 7'd0},
		'{spq_pkg::ACT_INSERT, 32'h8000_0000, 64'h1, 1'b0, 1'b0, 32'h0, 64'h0, 7'd0},
		'{spq_pkg::ACT_REMOVE, 32'h1234_5678, 64'h0, 1'b0, 1'b0, 32'h0, 64'h0, 7'd0},
		'{spq_pkg::ACT_REMOVE, 32'h0, 64'h1, 1'b0, 1'b0, 32'h0, 64'h0, 7'd0},
		'{spq_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 64'h0, 1'b0, 1'b0, 32'h0, 64'h0, 7'd0},
		'{spq_pkg::ACT_REMOVE, 32'h0, 64'h0, 1'b0, 1'b0, 32'h0, 64'h0, 7'd0},
		// The queue is empty again.
		'{spq_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			1'b0, 32'h0, 64'h0, 7'd0},
		'{spq_pkg::ACT_INSERT, 32'hC3C3_C3C3, 64'h3C3C_3C3C_3C3C_3C3C, 1'b0,
			1'b0, 32'h0, 64'h0, 7'd0},
		'{spq_pkg::ACT_REMOVE, 32'h0, 64'h0, 1'b0, 1'b0, 32'h0, 64'h0, 7'd0}
	};

	// Behavioral copy of the queue contents.
	logic [spq_pkg::KEY_BITS-1:0]   model_keys [spq_pkg::QUEUE_DEPTH];
	logic [spq_pkg::VALUE_BITS-1:0] model_values [spq_pkg::QUEUE_DEPTH];
	int                             model_count = 0;

	queue_outcome_t expected_outcomes [$];

	// Item being driven and its typed-in result, if any.
	logic                           cur_act;
	logic [spq_pkg::KEY_BITS-1:0]   cur_key;
	logic [spq_pkg::VALUE_BITS-1:0] cur_value;
	logic                           cur_fixed;
	queue_outcome_t                 cur_typed;

	// Random workload state.
	workload_t                    load_kind = LOAD_FILL;
	int                           load_left = 0;
	int                           loads_started = 0;
	bit                           load_narrow = 1'b0;
	logic [spq_pkg::KEY_BITS-1:0] key_pool [16];

	// Run statistics.
	int mismatch_count = 0;
	int results_seen = 0;
	int inserts_done = 0;
	int replaces_done = 0;
	int removes_done = 0;
	int removes_on_empty = 0;
	int inserts_on_full = 0;
	int peak_count = 0;
	int issued = 0;
	int accepted = 0;
	int idle_cycles = 0;

	sorted_priority_queue_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.entry_key    (entry_key),
		.entry_value  (entry_value),
		.done         (done),
		.success      (success),
		.result_key   (result_key),
		.result_value (result_value),
		.entries_held (entries_held)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("ERROR at %0t: %s is %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Apply one operation to the model queue and work out its result.
	task automatic apply_queue_op(input logic act, input logic [spq_pkg::KEY_BITS-1:0] key,
			input logic [spq_pkg::VALUE_BITS-1:0] value, output queue_outcome_t outcome);
		int slot;
		int j;
		outcome = '0;
		if (act == spq_pkg::ACT_REMOVE) begin
			if (model_count == 0) begin
				removes_on_empty++;
			end else begin
				outcome.ok    = 1'b1;
				outcome.key   = model_keys[0];
				outcome.value = model_values[0];
				for (j = 1; j < model_count; j++) begin
					model_keys[j-1]   = model_keys[j];
					model_values[j-1] = model_values[j];
				end
				model_count--;
				removes_done++;
			end
		end else begin
			// First slot whose key is not above the new key.
			slot = 0;
			while (slot < model_count && model_keys[slot] > key)
				slot++;
			if (slot < model_count && model_keys[slot] == key) begin
				model_values[slot] = value;
				outcome.ok = 1'b1;
				replaces_done++;
			end else if (model_count >= spq_pkg::QUEUE_DEPTH) begin
				inserts_on_full++;
			end else begin
				for (j = model_count; j > slot; j--) begin
					model_keys[j]   = model_keys[j-1];
					model_values[j] = model_values[j-1];
				end
				model_keys[slot]   = key;
				model_values[slot] = value;
				model_count++;
				outcome.ok = 1'b1;
				inserts_done++;
				if (model_count > peak_count)
					peak_count = model_count;
			end
			if (outcome.ok) begin
				outcome.key   = key;
				outcome.value = value;
			end
		end
		outcome.held = spq_pkg::ENTRIES_BITS'(model_count);
	endtask

	// Share of cycles in which the sender idles, per quarter of the random part.
	function automatic int sender_idle_pct(input int phase);
		case (phase)
			1:       return 50;
			3:       return 7;
			default: return 0;
		endcase
	endfunction

	function automatic logic [spq_pkg::KEY_BITS-1:0] extreme_key();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return spq_pkg::KEY_BITS'(1);
			2:       return '1;
			default: return '1 - 1;
		endcase
	endfunction

	// Pick the next random operation from the current workload.
	task automatic make_random_item();
		int remove_pct;
		int held_pct;
		int roll;
		int i;
		if (load_left == 0) begin
			// The first workload fills the queue so that full-queue cases show up early.
			if (loads_started == 0) begin
				load_kind = LOAD_FILL;
				load_left = 110;
			end else begin
				roll = $urandom_range(0, 99);
				load_kind = (roll < 40) ? LOAD_FILL : (roll < 65) ? LOAD_DRAIN : LOAD_MIXED;
				load_left = $urandom_range(30, 160);
			end
			load_narrow = 1'($urandom_range(0, 1));
			for (i = 0; i < 16; i++)
				key_pool[i] = $urandom;
			loads_started++;
		end
		load_left--;
		case (load_kind)
			LOAD_FILL:  remove_pct = 5;
			LOAD_DRAIN: remove_pct = 85;
			default:    remove_pct = 50;
		endcase
		held_pct = (load_kind == LOAD_FILL) ? 10 : 25;
		cur_fixed = 1'b0;
		cur_typed = '0;
		if ($urandom_range(0, 99) < remove_pct) begin
			cur_act   = spq_pkg::ACT_REMOVE;
			cur_key   = $urandom;
			cur_value = {$urandom, $urandom};
		end else begin
			cur_act = spq_pkg::ACT_INSERT;
			roll = $urandom_range(0, 99);
			if (roll < held_pct && model_count > 0)
				cur_key = model_keys[$urandom_range(0, model_count - 1)];
			else if (roll < held_pct + 8)
				cur_key = extreme_key();
			else if (load_narrow)
				cur_key = key_pool[$urandom_range(0, 15)];
			else
				cur_key = $urandom;
			roll = $urandom_range(0, 99);
			if (roll < 4)
				cur_value = '0;
			else if (roll < 8)
				cur_value = '1;
			else
				cur_value = {$urandom, $urandom};
		end
	endtask

	// Stimulus: reset, then the directed table, then random workloads.
	initial begin
		queue_outcome_t outcome;
		bit             idle;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (accepted < TOTAL_ITEMS) begin
			@(posedge clk);
			// Record a transfer of the item on the ports.
			if (start && !busy) begin
				apply_queue_op(cur_act, cur_key, cur_value, outcome);
				if (cur_fixed)
					outcome = cur_typed;
				expected_outcomes.push_back(outcome);
				accepted++;
			end
			// Offer the next item unless the current one is still waiting.
			if (!(start && busy)) begin
				idle = 1'b0;
				if (issued >= DIRECTED_ROWS && issued < TOTAL_ITEMS)
					idle = $urandom_range(0, 99) < sender_idle_pct(
						(issued - DIRECTED_ROWS) * 4 / RANDOM_ITEMS);
				if (issued == TOTAL_ITEMS || idle) begin
					start <= 1'b0;
				end else begin
					if (issued < DIRECTED_ROWS) begin
						cur_act   = directed_rows[issued].act;
						cur_key   = directed_rows[issued].key;
						cur_value = directed_rows[issued].value;
						cur_fixed = directed_rows[issued].fixed;
						cur_typed = '{directed_rows[issued].ok, directed_rows[issued].rkey,
							directed_rows[issued].rvalue, directed_rows[issued].held};
					end else begin
						make_random_item();
					end
					start       <= 1'b1;
					action      <= cur_act;
					entry_key   <= cur_key;
					entry_value <= cur_value;
					issued++;
				end
			end
		end
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		$display("Ran %0d operations: %0d new entries, %0d value replacements, %0d removes.",
			accepted, inserts_done, replaces_done, removes_done);
		$display("Rejected %0d removes on empty and %0d inserts on full; peak fill %0d of %0d.",
			removes_on_empty, inserts_on_full, peak_count, spq_pkg::QUEUE_DEPTH);
		if (mismatch_count == 0 && results_seen == accepted)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		queue_outcome_t want;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch("result with nothing expected, key", 64'(result_key), 64'h0);
			end else begin
				want = expected_outcomes.pop_front();
				results_seen++;
				if (success !== want.ok)
					report_mismatch("success", 64'(success), 64'(want.ok));
				if (result_key !== want.key)
					report_mismatch("result_key", 64'(result_key), 64'(want.key));
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (entries_held !== want.held)
					report_mismatch("entries_held", 64'(entries_held), 64'(want.held));
			end
		end
	end

	// Watchdog: end the run when no transfer and no result happen for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer or result for %0d cycles.", STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule

/* sorted_priority_queue_top.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_top.sv
dv/tb_sorted_priority_queue_top.sv
